/* sv/link_session_supervisor_top_macros.svh */
// Assertion macros for the link session supervisor checker.
// Included by the checker file; depends on nothing else.
`ifndef LINK_SESSION_SUPERVISOR_TOP_MACROS_SVH
`define LINK_SESSION_SUPERVISOR_TOP_MACROS_SVH

// Consequent checked at the same clock edge as the antecedent.
`define LSS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked at the clock edge after the antecedent.
`define LSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/lss_pkg.sv */
// Shared widths and codes for the link session supervisor.
// Used by every RTL file and the checker; depends on nothing.
package lss_pkg;

    // Field and datapath widths.
    localparam int REG_W   = 22;
    localparam int TIME_W  = 32;
    localparam int COUNT_W = 16;
    localparam int JIT_W   = REG_W + 1;

    // Jitter is a quarter of the delay, spread over twice that quarter.
    localparam int JITTER_SHIFT = 2;

    // Input actions.
    localparam logic [1:0] ACT_TICK       = 2'd0;
    localparam logic [1:0] ACT_CONNECT    = 2'd1;
    localparam logic [1:0] ACT_DISCONNECT = 2'd2;
    localparam logic [1:0] ACT_EVENT      = 2'd3;

    // Link event kinds, also the bit positions of the pending flags.
    localparam logic [1:0] EV_OPENED = 2'd0;
    localparam logic [1:0] EV_CLOSED = 2'd1;
    localparam logic [1:0] EV_ERROR  = 2'd2;
    localparam logic [1:0] EV_AUTHED = 2'd3;

    // Session phases as reported on the result channel.
    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_OPENING = 3'd1;
    localparam logic [2:0] PH_AUTH    = 3'd2;
    localparam logic [2:0] PH_UP      = 3'd3;
    localparam logic [2:0] PH_BACKOFF = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] REG_BASE = 2'd0;
    localparam logic [1:0] REG_MAX  = 2'd1;
    localparam logic [1:0] REG_AUTH = 2'd2;
    localparam logic [1:0] REG_BEAT = 2'd3;

    // Configuration reset values.
    localparam logic [REG_W-1:0] BASE_RESET = 22'd1000;
    localparam logic [REG_W-1:0] MAX_RESET  = 22'd60000;
    localparam logic [REG_W-1:0] AUTH_RESET = 22'd10000;
    localparam logic [REG_W-1:0] BEAT_RESET = 22'd30000;

endpackage

/* sv/lss_backoff_dbl.sv */
// Serial back-off doubler: doubles the base delay once per cycle, then clamps.
// Depends on lss_pkg.
module lss_backoff_dbl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [lss_pkg::REG_W-1:0]    base_ms,
    input  logic [lss_pkg::REG_W-1:0]    max_ms,
    input  logic [lss_pkg::COUNT_W-1:0]  count,
    output logic                         done,
    output logic [lss_pkg::REG_W-1:0]    backoff_ms
);

    localparam int DW = lss_pkg::REG_W + 1;

    logic [DW-1:0]                b_reg, b_next;
    logic [lss_pkg::COUNT_W-1:0]  cnt_reg, cnt_next;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [DW-1:0]                max_ext;

    assign max_ext = {1'b0, max_ms};

    // One doubling per cycle while attempts remain and the delay is below the ceiling.
    // A zero delay never grows, so it stops at once.
    always_comb begin
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            b_next    = {1'b0, base_ms};
            cnt_next  = count;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (cnt_reg != '0 && b_reg != '0 && b_reg < max_ext) begin
                b_next   = {b_reg[DW-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
            end else begin
                if (b_reg > max_ext) begin
                    b_next = max_ext;
                end
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Working value and step count.
    always_ff @(posedge aclk) begin
        b_reg   <= b_next;
        cnt_reg <= cnt_next;
    end

    assign done       = done_reg;
    assign backoff_ms = b_reg[lss_pkg::REG_W-1:0];

endmodule

/* sv/lss_jitter_div.sv */
// Jittered delay: value - value/4 + (now mod 2*(value/4)), remainder found one bit a cycle.
// Depends on lss_pkg.
module lss_jitter_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [lss_pkg::REG_W-1:0]    value_ms,
    input  logic [lss_pkg::TIME_W-1:0]   now_ms,
    output logic                         done,
    output logic [lss_pkg::JIT_W-1:0]    jitter_ms
);

    localparam int QW = lss_pkg::REG_W - lss_pkg::JITTER_SHIFT;
    localparam int DW = QW + 1;
    localparam int CW = $clog2(lss_pkg::TIME_W);

    typedef enum logic [2:0] {
        JS_IDLE = 3'b001,
        JS_DIV  = 3'b010,
        JS_SUM  = 3'b100
    } jstate_t;

    jstate_t                      state_reg, state_next;
    logic                         done_reg, done_next;
    logic [DW-1:0]                d_reg, d_next;
    logic [lss_pkg::REG_W-1:0]    part_reg, part_next;
    logic [DW-1:0]                rem_reg, rem_next;
    logic [lss_pkg::TIME_W-1:0]   sh_reg, sh_next;
    logic [CW-1:0]                cnt_reg, cnt_next;
    logic [lss_pkg::JIT_W-1:0]    res_reg, res_next;
    logic [QW-1:0]                q;
    logic [DW:0]                  trial;
    logic [DW:0]                  diff;

    assign q     = value_ms[lss_pkg::REG_W-1:lss_pkg::JITTER_SHIFT];
    assign trial = {rem_reg, sh_reg[lss_pkg::TIME_W-1]};
    assign diff  = trial - {1'b0, d_reg};

    // Restoring remainder: shift in one bit of now, subtract the divisor when it fits.
    always_comb begin
        state_next = state_reg;
        done_next  = 1'b0;
        d_next     = d_reg;
        part_next  = part_reg;
        rem_next   = rem_reg;
        sh_next    = sh_reg;
        cnt_next   = cnt_reg;
        res_next   = res_reg;
        case (state_reg)
            JS_IDLE: begin
                if (start) begin
                    if (q == '0) begin
                        // A quarter of zero leaves the delay unjittered.
                        res_next  = {1'b0, value_ms};
                        done_next = 1'b1;
                    end else begin
                        d_next     = {q, 1'b0};
                        part_next  = value_ms - lss_pkg::REG_W'(q);
                        rem_next   = '0;
                        sh_next    = now_ms;
                        cnt_next   = CW'(lss_pkg::TIME_W - 1);
                        state_next = JS_DIV;
                    end
                end
            end
            JS_DIV: begin
                rem_next = diff[DW] ? trial[DW-1:0] : diff[DW-1:0];
                sh_next  = {sh_reg[lss_pkg::TIME_W-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = JS_SUM;
                end
            end
            JS_SUM: begin
                res_next   = {1'b0, part_reg} + lss_pkg::JIT_W'(rem_reg);
                done_next  = 1'b1;
                state_next = JS_IDLE;
            end
            default: begin
                state_next = JS_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= JS_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        d_reg    <= d_next;
        part_reg <= part_next;
        rem_reg  <= rem_next;
        sh_reg   <= sh_next;
        cnt_reg  <= cnt_next;
        res_reg  <= res_next;
    end

    assign done      = done_reg;
    assign jitter_ms = res_reg;

endmodule

/* sv/link_session_supervisor_top.sv */
// Link session supervisor with exponential back-off; uses lss_pkg, lss_backoff_dbl, lss_jitter_div.
// Items that set no deadline by jitter pass from evaluation straight to the result.
// A refused open runs the jitter unit's 32-step bit-serial remainder, skipped for a base under four.
// Entering back-off runs the doubler (at most 22 doublings), then the jitter unit.
// One item at a time; the next is taken the cycle after the result is registered.
// Synchronous active-low reset: phase idle, counters and flags clear, registers to defaults.
module link_session_supervisor_top #(
    parameter int CFG_INDEX_W = 4
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Configuration writes.
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_INDEX_W-1:0]       cfg_index,
    input  logic [lss_pkg::REG_W-1:0]    cfg_data,
    // Input items.
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_action,
    input  logic [1:0]                   s_event_kind,
    input  logic [lss_pkg::TIME_W-1:0]   s_now_ms,
    input  logic                         s_open_accepted,
    // Result items.
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [2:0]                   m_session_state,
    output logic                         m_open_request,
    output logic                         m_close_request,
    output logic                         m_auth_request,
    output logic                         m_heartbeat_request,
    output logic [lss_pkg::REG_W-1:0]    m_current_backoff_ms,
    output logic [lss_pkg::COUNT_W-1:0]  m_retry_count
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_EVAL   = 5'b00010,
        ST_DOUBLE = 5'b00100,
        ST_JITTER = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    typedef enum logic [1:0] {
        JOB_NONE,
        JOB_REJECT,
        JOB_BACKOFF
    } job_t;

    typedef struct packed {
        logic open;
        logic close;
        logic auth;
        logic beat;
    } pulse_t;

    localparam logic [lss_pkg::COUNT_W-1:0] COUNT_MAX = '1;

    function automatic logic [lss_pkg::COUNT_W-1:0] sat_inc(
        input logic [lss_pkg::COUNT_W-1:0] v
    );
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

    state_t                       state_reg, state_next;

    // Configuration registers.
    logic [lss_pkg::REG_W-1:0]    base_reg, base_next;
    logic [lss_pkg::REG_W-1:0]    max_reg, max_next;
    logic [lss_pkg::REG_W-1:0]    auth_reg, auth_next;
    logic [lss_pkg::REG_W-1:0]    beat_reg, beat_next;

    // Session state.
    logic [2:0]                   phase_reg, phase_next;
    logic [3:0]                   pending_reg, pending_next;
    logic [lss_pkg::TIME_W-1:0]   deadline_reg, deadline_next;
    logic [lss_pkg::TIME_W-1:0]   last_beat_reg, last_beat_next;
    logic [lss_pkg::COUNT_W-1:0]  attempts_reg, attempts_next;
    logic [lss_pkg::REG_W-1:0]    backoff_reg, backoff_next;
    logic                         link_open_reg, link_open_next;
    pulse_t                       pulse_reg, pulse_next;

    // Captured input beat.
    logic [1:0]                   action_reg;
    logic [1:0]                   kind_reg;
    logic [lss_pkg::TIME_W-1:0]   now_reg;
    logic                         acc_reg;
    logic [lss_pkg::TIME_W-1:0]   beat_sum_reg;

    // Output register.
    logic                         m_valid_reg, m_valid_next;
    logic                         out_load;
    logic [2:0]                   out_state_reg;
    pulse_t                       out_pulse_reg;
    logic [lss_pkg::REG_W-1:0]    out_backoff_reg;
    logic [lss_pkg::COUNT_W-1:0]  out_retry_reg;

    // Step evaluation results.
    logic [2:0]                   ev_phase;
    logic [3:0]                   ev_pending;
    logic                         ev_link_open;
    logic [lss_pkg::COUNT_W-1:0]  ev_attempts;
    logic [lss_pkg::REG_W-1:0]    ev_backoff;
    logic [lss_pkg::TIME_W-1:0]   ev_deadline;
    logic [lss_pkg::TIME_W-1:0]   ev_last_beat;
    pulse_t                       ev_pulse;
    job_t                         ev_job;
    logic                         ev_open;
    logic                         ev_fail1;
    logic                         ev_fail2;

    logic [lss_pkg::TIME_W-1:0]   dl_diff;
    logic [lss_pkg::TIME_W-1:0]   hb_diff;
    logic                         dl_passed;
    logic                         hb_passed;
    logic                         fail_pending;
    logic                         zero_backoff;

    // Serial units.
    logic                         dbl_start;
    logic                         dbl_done;
    logic [lss_pkg::REG_W-1:0]    dbl_backoff;
    logic                         jit_start;
    logic [lss_pkg::REG_W-1:0]    jit_value;
    logic                         jit_done;
    logic [lss_pkg::JIT_W-1:0]    jit_ms;

    lss_backoff_dbl u_dbl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (dbl_start),
        .base_ms    (base_reg),
        .max_ms     (max_reg),
        .count      (ev_attempts),
        .done       (dbl_done),
        .backoff_ms (dbl_backoff)
    );

    lss_jitter_div u_jit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (jit_start),
        .value_ms  (jit_value),
        .now_ms    (now_reg),
        .done      (jit_done),
        .jitter_ms (jit_ms)
    );

    assign jit_value = (state_reg == ST_DOUBLE) ? dbl_backoff : base_reg;

    // Wrap-safe deadline tests: passed when the difference is not negative.
    assign dl_diff      = now_reg - deadline_reg;
    assign hb_diff      = now_reg - beat_sum_reg;
    assign dl_passed    = ~dl_diff[lss_pkg::TIME_W-1];
    assign hb_passed    = ~hb_diff[lss_pkg::TIME_W-1];
    assign fail_pending = pending_reg[lss_pkg::EV_CLOSED] | pending_reg[lss_pkg::EV_ERROR];
    // The doubled and clamped delay is zero exactly when base or ceiling is zero.
    assign zero_backoff = (base_reg == '0) || (max_reg == '0);

    // Evaluate one step of the session against the captured beat.
    always_comb begin
        ev_phase     = phase_reg;
        ev_pending   = pending_reg;
        ev_link_open = link_open_reg;
        ev_attempts  = attempts_reg;
        ev_backoff   = backoff_reg;
        ev_deadline  = deadline_reg;
        ev_last_beat = last_beat_reg;
        ev_pulse     = '0;
        ev_job       = JOB_NONE;
        ev_open      = 1'b0;
        ev_fail1     = 1'b0;
        ev_fail2     = 1'b0;
        case (action_reg)
            lss_pkg::ACT_TICK: begin
                case (phase_reg)
                    lss_pkg::PH_OPENING: begin
                        if (pending_reg[lss_pkg::EV_OPENED]) begin
                            ev_pending[lss_pkg::EV_OPENED] = 1'b0;
                            ev_phase      = lss_pkg::PH_AUTH;
                            ev_deadline   = now_reg + lss_pkg::TIME_W'(auth_reg);
                            ev_pulse.auth = 1'b1;
                        end
                        if (fail_pending) begin
                            ev_pending[lss_pkg::EV_CLOSED] = 1'b0;
                            ev_pending[lss_pkg::EV_ERROR]  = 1'b0;
                            ev_fail1 = 1'b1;
                        end
                    end
                    lss_pkg::PH_AUTH: begin
                        if (pending_reg[lss_pkg::EV_AUTHED]) begin
                            ev_pending[lss_pkg::EV_AUTHED] = 1'b0;
                            ev_phase     = lss_pkg::PH_UP;
                            ev_last_beat = now_reg;
                            ev_attempts  = '0;
                            ev_backoff   = '0;
                        end
                        if (fail_pending) begin
                            ev_pending[lss_pkg::EV_CLOSED] = 1'b0;
                            ev_pending[lss_pkg::EV_ERROR]  = 1'b0;
                            ev_fail1 = 1'b1;
                        end
                        // After a failure the fresh deadline has passed only for a zero delay.
                        if (fail_pending ? zero_backoff : dl_passed) begin
                            ev_fail2 = 1'b1;
                        end
                    end
                    lss_pkg::PH_UP: begin
                        if (fail_pending) begin
                            ev_pending[lss_pkg::EV_CLOSED] = 1'b0;
                            ev_pending[lss_pkg::EV_ERROR]  = 1'b0;
                            ev_fail1 = 1'b1;
                        end else if (hb_passed) begin
                            ev_pulse.beat = 1'b1;
                            ev_last_beat  = now_reg;
                        end
                    end
                    lss_pkg::PH_BACKOFF: begin
                        if (dl_passed) begin
                            ev_open = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            lss_pkg::ACT_CONNECT: begin
                ev_open = 1'b1;
            end
            lss_pkg::ACT_DISCONNECT: begin
                if (link_open_reg) begin
                    ev_pulse.close = 1'b1;
                end
                ev_link_open = 1'b0;
                ev_phase     = lss_pkg::PH_IDLE;
                ev_pending   = '0;
            end
            default: begin
                ev_pending = pending_reg | (4'b0001 << kind_reg);
            end
        endcase

        // Back-off entry, once or twice in one step.
        if (ev_fail1 || ev_fail2) begin
            if (ev_link_open) begin
                ev_pulse.close = 1'b1;
            end
            ev_link_open = 1'b0;
            ev_phase     = lss_pkg::PH_BACKOFF;
            ev_job       = JOB_BACKOFF;
        end
        if (ev_fail1) begin
            ev_attempts = sat_inc(ev_attempts);
        end
        if (ev_fail2) begin
            ev_attempts = sat_inc(ev_attempts);
        end

        // Open attempt.
        if (ev_open) begin
            ev_pending = '0;
            if (ev_link_open) begin
                ev_pulse.close = 1'b1;
            end
            if (acc_reg) begin
                ev_phase      = lss_pkg::PH_OPENING;
                ev_link_open  = 1'b1;
                ev_pulse.open = 1'b1;
            end else begin
                ev_link_open = 1'b0;
                ev_phase     = lss_pkg::PH_BACKOFF;
                ev_job       = JOB_REJECT;
            end
        end
    end

    // Sequencer and register updates.
    always_comb begin
        state_next     = state_reg;
        base_next      = base_reg;
        max_next       = max_reg;
        auth_next      = auth_reg;
        beat_next      = beat_reg;
        phase_next     = phase_reg;
        pending_next   = pending_reg;
        deadline_next  = deadline_reg;
        last_beat_next = last_beat_reg;
        attempts_next  = attempts_reg;
        backoff_next   = backoff_reg;
        link_open_next = link_open_reg;
        pulse_next     = pulse_reg;
        dbl_start      = 1'b0;
        jit_start      = 1'b0;
        out_load       = 1'b0;

        // Configuration beats.
        if (cfg_valid) begin
            case (cfg_index)
                CFG_INDEX_W'(lss_pkg::REG_BASE): base_next = cfg_data;
                CFG_INDEX_W'(lss_pkg::REG_MAX):  max_next  = cfg_data;
                CFG_INDEX_W'(lss_pkg::REG_AUTH): auth_next = cfg_data;
                CFG_INDEX_W'(lss_pkg::REG_BEAT): beat_next = cfg_data;
                default: begin
                end
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                phase_next     = ev_phase;
                pending_next   = ev_pending;
                deadline_next  = ev_deadline;
                last_beat_next = ev_last_beat;
                attempts_next  = ev_attempts;
                backoff_next   = ev_backoff;
                link_open_next = ev_link_open;
                pulse_next     = ev_pulse;
                case (ev_job)
                    JOB_BACKOFF: begin
                        dbl_start  = 1'b1;
                        state_next = ST_DOUBLE;
                    end
                    JOB_REJECT: begin
                        jit_start  = 1'b1;
                        state_next = ST_JITTER;
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_DOUBLE: begin
                if (dbl_done) begin
                    backoff_next = dbl_backoff;
                    jit_start    = 1'b1;
                    state_next   = ST_JITTER;
                end
            end
            ST_JITTER: begin
                if (jit_done) begin
                    deadline_next = now_reg + lss_pkg::TIME_W'(jit_ms);
                    state_next    = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid: set on load, cleared when the beat is taken.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control and session state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            base_reg      <= lss_pkg::BASE_RESET;
            max_reg       <= lss_pkg::MAX_RESET;
            auth_reg      <= lss_pkg::AUTH_RESET;
            beat_reg      <= lss_pkg::BEAT_RESET;
            phase_reg     <= lss_pkg::PH_IDLE;
            pending_reg   <= '0;
            deadline_reg  <= '0;
            last_beat_reg <= '0;
            attempts_reg  <= '0;
            backoff_reg   <= '0;
            link_open_reg <= 1'b0;
            pulse_reg     <= '0;
        end else begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            base_reg      <= base_next;
            max_reg       <= max_next;
            auth_reg      <= auth_next;
            beat_reg      <= beat_next;
            phase_reg     <= phase_next;
            pending_reg   <= pending_next;
            deadline_reg  <= deadline_next;
            last_beat_reg <= last_beat_next;
            attempts_reg  <= attempts_next;
            backoff_reg   <= backoff_next;
            link_open_reg <= link_open_next;
            pulse_reg     <= pulse_next;
        end
    end

    // Capture the input beat and the heartbeat due time.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            action_reg   <= s_action;
            kind_reg     <= s_event_kind;
            now_reg      <= s_now_ms;
            acc_reg      <= s_open_accepted;
            beat_sum_reg <= last_beat_reg + lss_pkg::TIME_W'(beat_reg);
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_state_reg   <= phase_reg;
            out_pulse_reg   <= pulse_reg;
            out_backoff_reg <= backoff_reg;
            out_retry_reg   <= attempts_reg;
        end
    end

    assign cfg_ready            = 1'b1;
    assign s_ready              = (state_reg == ST_IDLE);
    assign m_valid              = m_valid_reg;
    assign m_session_state      = out_state_reg;
    assign m_open_request       = out_pulse_reg.open;
    assign m_close_request      = out_pulse_reg.close;
    assign m_auth_request       = out_pulse_reg.auth;
    assign m_heartbeat_request  = out_pulse_reg.beat;
    assign m_current_backoff_ms = out_backoff_reg;
    assign m_retry_count        = out_retry_reg;

endmodule

/* sv/lss_checker.sv */
// Port-level checks for the link session supervisor, bound to the top level.
// Depends on lss_pkg and link_session_supervisor_top_macros.svh.
`include "link_session_supervisor_top_macros.svh"

module lss_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [2:0]                   m_session_state,
    input logic                         m_open_request,
    input logic                         m_close_request,
    input logic                         m_auth_request,
    input logic                         m_heartbeat_request,
    input logic [lss_pkg::REG_W-1:0]    m_current_backoff_ms,
    input logic [lss_pkg::COUNT_W-1:0]  m_retry_count
);

    logic [lss_pkg::REG_W+lss_pkg::COUNT_W+6:0] result_word;
    logic                                       up_result;

    assign result_word = {m_session_state, m_open_request, m_close_request, m_auth_request,
                          m_heartbeat_request, m_current_backoff_ms, m_retry_count};
    assign up_result   = m_valid && (m_session_state == lss_pkg::PH_UP);

    // A stalled result beat keeps its valid and its payload.
    `LSS_ASSERT_NEXT(a_result_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(result_word), "result beat changed while stalled")

    // Only one item is in work at a time.
    `LSS_ASSERT_NEXT(a_one_in_work, aclk, aresetn, s_valid && s_ready, !s_ready, "input taken while an item is in work")

    // An issued open always leaves the session opening.
    `LSS_ASSERT_SAME(a_open_phase, aclk, aresetn, m_valid && m_open_request, m_session_state == lss_pkg::PH_OPENING, "open issued outside opening")

    // An established session carries no retry history.
    `LSS_ASSERT_SAME(a_up_clean, aclk, aresetn, up_result, (m_retry_count == '0) && (m_current_backoff_ms == '0), "session up with retry history")

endmodule

bind link_session_supervisor_top lss_checker u_lss_checker (.*);

/* test/link_session_supervisor_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the link session supervisor: directed table, then random
// session flows under several register settings. Depends on lss_pkg and the top level.
module link_session_supervisor_top_tb;

    localparam int LIMIT_CYCLES   = 600000;
    localparam int ITEMS_PER_SET  = 105;
    localparam int SETTING_COUNT  = 8;
    localparam int DRAIN_CYCLES   = 80;
    localparam int LONG_HOLD      = 400;
    localparam logic [3:0] REG_SPARE = 4'd9;

    typedef struct {
        logic [1:0]  action;
        logic [1:0]  kind;
        logic [31:0] now;
        logic        accepted;
    } session_in_t;

    typedef struct {
        logic [2:0]  state;
        logic        open_req;
        logic        close_req;
        logic        auth_req;
        logic        beat_req;
        logic [21:0] backoff;
        logic [15:0] retries;
    } session_out_t;

    typedef struct {
        session_in_t  stim;
        bit           typed;
        session_out_t want;
    } dir_row_t;

    logic                         aclk = 1'b0;
    logic                         aresetn;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [3:0]                   cfg_index;
    logic [lss_pkg::REG_W-1:0]    cfg_data;
    logic                         s_valid;
    logic                         s_ready;
    logic [1:0]                   s_action;
    logic [1:0]                   s_event_kind;
    logic [lss_pkg::TIME_W-1:0]   s_now_ms;
    logic                         s_open_accepted;
    logic                         m_valid;
    logic                         m_ready;
    logic [2:0]                   m_session_state;
    logic                         m_open_request;
    logic                         m_close_request;
    logic                         m_auth_request;
    logic                         m_heartbeat_request;
    logic [lss_pkg::REG_W-1:0]    m_current_backoff_ms;
    logic [lss_pkg::COUNT_W-1:0]  m_retry_count;

    // Supervisor state as predicted.
    logic [2:0]  sv_phase;
    logic [3:0]  sv_pending;
    logic [31:0] sv_deadline;
    logic [31:0] sv_last_beat;
    logic [15:0] sv_attempts;
    logic [21:0] sv_backoff;
    logic        sv_link_open;
    logic        pulse_open, pulse_close, pulse_auth, pulse_beat;
    logic [31:0] cfg_base, cfg_max, cfg_auth, cfg_beat;

    session_out_t expected_status_q[$];
    int          fault_count = 0;
    logic [31:0] wall_ms;
    bit          calm = 1'b0;
    bit          hold_req = 1'b0;

    // Register settings per random phase: base, max, auth timeout, heartbeat period.
    logic [21:0] reg_plan [SETTING_COUNT][4] = '{
        '{22'd100,      22'd3000,     22'd400,      22'd250},
        '{22'd0,        22'd0,        22'd0,        22'd0},
        '{22'h3FFFFF,   22'h3FFFFF,   22'h3FFFFF,   22'h3FFFFF},
        '{22'd3,        22'h3FFFFF,   22'd1,        22'd1},
        '{22'd5000,     22'd100,      22'd50,       22'd70},
        '{22'd1,        22'd1,        22'd2,        22'd3},
        '{22'd0,        22'd0,        22'd0,        22'd0},
        '{22'd200,      22'd6000,     22'd500,      22'd300}
    };

    link_session_supervisor_top dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_action             (s_action),
        .s_event_kind         (s_event_kind),
        .s_now_ms             (s_now_ms),
        .s_open_accepted      (s_open_accepted),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_session_state      (m_session_state),
        .m_open_request       (m_open_request),
        .m_close_request      (m_close_request),
        .m_auth_request       (m_auth_request),
        .m_heartbeat_request  (m_heartbeat_request),
        .m_current_backoff_ms (m_current_backoff_ms),
        .m_retry_count        (m_retry_count)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // A deadline counts as reached when the wrapped difference is not negative.
    function automatic bit is_due(logic [31:0] now, logic [31:0] mark);
        logic [31:0] diff;
        diff = now - mark;
        return ~diff[31];
    endfunction

    // Delay with a quarter-width spread drawn from the current time.
    function automatic logic [31:0] spread_delay(logic [31:0] b, logic [31:0] now);
        logic [31:0] quarter;
        quarter = b >> lss_pkg::JITTER_SHIFT;
        if (quarter == 32'd0) return b;
        return b - quarter + now % (quarter << 1);
    endfunction

    function automatic void drop_link();
        if (sv_link_open) begin
            pulse_close = 1'b1;
            sv_link_open = 1'b0;
        end
    endfunction

    // Failure: count the attempt, double the base per attempt up to the ceiling.
    function automatic void start_backoff(logic [31:0] now);
        logic [31:0] b;
        int i;
        b = cfg_base;
        drop_link();
        sv_phase = lss_pkg::PH_BACKOFF;
        if (sv_attempts != 16'hFFFF) sv_attempts = sv_attempts + 16'd1;
        for (i = 0; i < int'(sv_attempts) && b < cfg_max; i++) b = b * 2;
        if (b > cfg_max) b = cfg_max;
        sv_backoff = b[21:0];
        sv_deadline = now + spread_delay(b, now);
    endfunction

    function automatic void try_open(logic [31:0] now, logic accepted);
        sv_pending = 4'd0;
        drop_link();
        if (accepted) begin
            sv_phase = lss_pkg::PH_OPENING;
            sv_link_open = 1'b1;
            pulse_open = 1'b1;
        end else begin
            sv_phase = lss_pkg::PH_BACKOFF;
            sv_deadline = now + spread_delay(cfg_base, now);
        end
    endfunction

    function automatic void on_tick(logic [31:0] now, logic accepted);
        case (sv_phase)
            lss_pkg::PH_OPENING: begin
                if (sv_pending[lss_pkg::EV_OPENED]) begin
                    sv_pending[lss_pkg::EV_OPENED] = 1'b0;
                    sv_phase = lss_pkg::PH_AUTH;
                    sv_deadline = now + cfg_auth;
                    pulse_auth = 1'b1;
                end
                if (sv_pending[lss_pkg::EV_CLOSED] || sv_pending[lss_pkg::EV_ERROR]) begin
                    sv_pending[lss_pkg::EV_CLOSED] = 1'b0;
                    sv_pending[lss_pkg::EV_ERROR] = 1'b0;
                    start_backoff(now);
                end
            end
            lss_pkg::PH_AUTH: begin
                if (sv_pending[lss_pkg::EV_AUTHED]) begin
                    sv_pending[lss_pkg::EV_AUTHED] = 1'b0;
                    sv_phase = lss_pkg::PH_UP;
                    sv_last_beat = now;
                    sv_attempts = 16'd0;
                    sv_backoff = 22'd0;
                end
                if (sv_pending[lss_pkg::EV_CLOSED] || sv_pending[lss_pkg::EV_ERROR]) begin
                    sv_pending[lss_pkg::EV_CLOSED] = 1'b0;
                    sv_pending[lss_pkg::EV_ERROR] = 1'b0;
                    start_backoff(now);
                end
                // The auth deadline is checked even after a success on the same tick.
                if (is_due(now, sv_deadline)) start_backoff(now);
            end
            lss_pkg::PH_UP: begin
                if (sv_pending[lss_pkg::EV_CLOSED] || sv_pending[lss_pkg::EV_ERROR]) begin
                    sv_pending[lss_pkg::EV_CLOSED] = 1'b0;
                    sv_pending[lss_pkg::EV_ERROR] = 1'b0;
                    start_backoff(now);
                end else if (is_due(now, sv_last_beat + cfg_beat)) begin
                    pulse_beat = 1'b1;
                    sv_last_beat = now;
                end
            end
            lss_pkg::PH_BACKOFF: begin
                if (is_due(now, sv_deadline)) try_open(now, accepted);
            end
            default: ;
        endcase
    endfunction

    // Advances the predicted supervisor by one beat and returns its status.
    function automatic session_out_t supervise_step(session_in_t it);
        session_out_t res;
        pulse_open = 1'b0;
        pulse_close = 1'b0;
        pulse_auth = 1'b0;
        pulse_beat = 1'b0;
        case (it.action)
            lss_pkg::ACT_TICK:    on_tick(it.now, it.accepted);
            lss_pkg::ACT_CONNECT: try_open(it.now, it.accepted);
            lss_pkg::ACT_DISCONNECT: begin
                drop_link();
                sv_phase = lss_pkg::PH_IDLE;
                sv_pending = 4'd0;
            end
            default: sv_pending[it.kind] = 1'b1;
        endcase
        res.state = sv_phase;
        res.open_req = pulse_open;
        res.close_req = pulse_close;
        res.auth_req = pulse_auth;
        res.beat_req = pulse_beat;
        res.backoff = sv_backoff;
        res.retries = sv_attempts;
        return res;
    endfunction

    function automatic void apply_setting(logic [3:0] idx, logic [21:0] data);
        case (idx)
            4'(lss_pkg::REG_BASE): cfg_base = {10'd0, data};
            4'(lss_pkg::REG_MAX):  cfg_max  = {10'd0, data};
            4'(lss_pkg::REG_AUTH): cfg_auth = {10'd0, data};
            4'(lss_pkg::REG_BEAT): cfg_beat = {10'd0, data};
            default: ;
        endcase
    endfunction

    function automatic dir_row_t dir(logic [1:0] a, logic [1:0] k, logic [31:0] t,
                                     logic acc);
        dir_row_t row;
        row.stim = '{a, k, t, acc};
        row.typed = 1'b0;
        row.want = '{lss_pkg::PH_IDLE, 1'b0, 1'b0, 1'b0, 1'b0, 22'd0, 16'd0};
        return row;
    endfunction

    function automatic dir_row_t dir_want(logic [1:0] a, logic [1:0] k, logic [31:0] t,
                                          logic acc, logic [2:0] st, logic op, logic cl,
                                          logic au, logic hb, logic [21:0] bo,
                                          logic [15:0] rc);
        dir_row_t row;
        row.stim = '{a, k, t, acc};
        row.typed = 1'b1;
        row.want = '{st, op, cl, au, hb, bo, rc};
        return row;
    endfunction

    // Random beat shaped by the predicted phase, so that most sequences make progress.
    function automatic session_in_t pick_item();
        session_in_t it;
        int r;
        r = $urandom_range(0, 99);
        it.action = lss_pkg::ACT_TICK;
        it.kind = 2'($urandom_range(0, 3));
        it.accepted = ($urandom_range(0, 7) != 0);
        wall_ms = wall_ms + $urandom_range(0, 30);
        if (r < 6) begin
            // Noise: any action, sometimes at an arbitrary time.
            it.action = 2'($urandom_range(0, 3));
            it.accepted = 1'($urandom_range(0, 1));
            if (r < 2) wall_ms = $urandom;
        end else begin
            case (sv_phase)
                lss_pkg::PH_IDLE: begin
                    if (r < 75) it.action = lss_pkg::ACT_CONNECT;
                    else if (r < 88) it.action = lss_pkg::ACT_EVENT;
                end
                lss_pkg::PH_OPENING: begin
                    if (r < 55) begin
                        it.action = lss_pkg::ACT_EVENT;
                        it.kind = lss_pkg::EV_OPENED;
                    end else if (r < 63) begin
                        it.action = lss_pkg::ACT_EVENT;
                        it.kind = (r % 2 == 0) ? lss_pkg::EV_CLOSED : lss_pkg::EV_ERROR;
                    end else if (r < 66) begin
                        it.action = lss_pkg::ACT_DISCONNECT;
                    end
                end
                lss_pkg::PH_AUTH: begin
                    if (r < 40) begin
                        it.action = lss_pkg::ACT_EVENT;
                        it.kind = lss_pkg::EV_AUTHED;
                    end else if (r < 47) begin
                        it.action = lss_pkg::ACT_EVENT;
                        it.kind = (r % 2 == 0) ? lss_pkg::EV_CLOSED : lss_pkg::EV_ERROR;
                    end else if (r < 50) begin
                        it.action = lss_pkg::ACT_CONNECT;
                    end else if (r < 70) begin
                        wall_ms = sv_deadline - 3 + $urandom_range(0, 6);
                    end
                end
                lss_pkg::PH_UP: begin
                    if (r < 10) begin
                        it.action = lss_pkg::ACT_EVENT;
                        it.kind = (r % 2 == 0) ? lss_pkg::EV_CLOSED : lss_pkg::EV_ERROR;
                    end else if (r < 13) begin
                        it.action = lss_pkg::ACT_DISCONNECT;
                    end else if (r < 16) begin
                        it.action = lss_pkg::ACT_CONNECT;
                    end else if (r < 22) begin
                        it.action = lss_pkg::ACT_EVENT;
                    end else if (r < 60) begin
                        wall_ms = sv_last_beat + cfg_beat - 2 + $urandom_range(0, 4);
                    end
                end
                lss_pkg::PH_BACKOFF: begin
                    if (r < 8) it.action = lss_pkg::ACT_CONNECT;
                    else if (r < 11) it.action = lss_pkg::ACT_DISCONNECT;
                    else if (r < 16) it.action = lss_pkg::ACT_EVENT;
                    else if (r < 70) wall_ms = sv_deadline - 2 + $urandom_range(0, 4);
                end
                default: ;
            endcase
        end
        it.now = wall_ms;
        return it;
    endfunction

    task automatic send_item(input session_in_t it);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_action <= it.action;
        s_event_kind <= it.kind;
        s_now_ms <= it.now;
        s_open_accepted <= it.accepted;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic cfg_write(input logic [3:0] idx, input logic [21:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        apply_setting(idx, data);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Stops offering beats and waits until every predicted status has come back.
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_status_q.size() != 0) @(posedge aclk);
    endtask

    // Result side: random stall bursts, plus one long hold on request.
    initial begin : result_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_left = LONG_HOLD - 1;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 17) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Each result beat is checked against the oldest predicted status.
    always @(posedge aclk) begin : status_check
        session_out_t want;
        session_out_t got;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_session_state, m_open_request, m_close_request, m_auth_request,
                    m_heartbeat_request, m_current_backoff_ms, m_retry_count};
            if (expected_status_q.size() == 0) begin
                if (fault_count < 10)
                    $display("unexpected result beat: state=%0d", got.state);
                fault_count++;
            end else begin
                want = expected_status_q.pop_front();
                if (got.state != want.state || got.open_req != want.open_req ||
                    got.close_req != want.close_req || got.auth_req != want.auth_req ||
                    got.beat_req != want.beat_req || got.backoff != want.backoff ||
                    got.retries != want.retries) begin
                    if (fault_count < 10) begin
                        $display("expected: st=%0d op=%0d cl=%0d au=%0d hb=%0d bo=%0d rc=%0d",
                                 want.state, want.open_req, want.close_req, want.auth_req,
                                 want.beat_req, want.backoff, want.retries);
                        $display("actual:   st=%0d op=%0d cl=%0d au=%0d hb=%0d bo=%0d rc=%0d",
                                 got.state, got.open_req, got.close_req, got.auth_req,
                                 got.beat_req, got.backoff, got.retries);
                    end
                    fault_count++;
                end
            end
        end
    end

    initial begin : watchdog
        #(LIMIT_CYCLES * 4);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        dir_row_t     directed_rows[$];
        session_in_t  it;
        session_out_t pred;
        int ph;
        int n;
        int gap;
        int j;

        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = 4'd0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_action = lss_pkg::ACT_TICK;
        s_event_kind = lss_pkg::EV_OPENED;
        s_now_ms = '0;
        s_open_accepted = 1'b0;

        cfg_base = 32'(lss_pkg::BASE_RESET);
        cfg_max = 32'(lss_pkg::MAX_RESET);
        cfg_auth = 32'(lss_pkg::AUTH_RESET);
        cfg_beat = 32'(lss_pkg::BEAT_RESET);
        sv_phase = lss_pkg::PH_IDLE;
        sv_pending = 4'd0;
        sv_deadline = 32'd0;
        sv_last_beat = 32'd0;
        sv_attempts = 16'd0;
        sv_backoff = 22'd0;
        sv_link_open = 1'b0;

        // Directed walk at reset settings, time crossing the wrap point early on.
        directed_rows.push_back(dir_want(lss_pkg::ACT_TICK, lss_pkg::EV_OPENED, 32'd0, 1'b0,
                                         lss_pkg::PH_IDLE, 0, 0, 0, 0, 22'd0, 16'd0));
        directed_rows.push_back(dir_want(lss_pkg::ACT_EVENT, lss_pkg::EV_AUTHED, 32'd5, 1'b1,
                                         lss_pkg::PH_IDLE, 0, 0, 0, 0, 22'd0, 16'd0));
        directed_rows.push_back(dir_want(lss_pkg::ACT_DISCONNECT, lss_pkg::EV_ERROR,
                                         32'hFFFF_FFFF, 1'b1,
                                         lss_pkg::PH_IDLE, 0, 0, 0, 0, 22'd0, 16'd0));
        // A refused open goes straight to back-off without counting an attempt.
        directed_rows.push_back(dir_want(lss_pkg::ACT_CONNECT, lss_pkg::EV_CLOSED,
                                         32'hFFFF_FFFF, 1'b0,
                                         lss_pkg::PH_BACKOFF, 0, 0, 0, 0, 22'd0, 16'd0));
        directed_rows.push_back(dir(lss_pkg::ACT_TICK, lss_pkg::EV_OPENED, 32'd0, 1'b1));
        directed_rows.push_back(dir_want(lss_pkg::ACT_CONNECT, lss_pkg::EV_OPENED, 32'd100, 1'b1,
                                         lss_pkg::PH_OPENING, 1, 0, 0, 0, 22'd0, 16'd0));
        // Connect on an open link closes it first.
        directed_rows.push_back(dir_want(lss_pkg::ACT_CONNECT, lss_pkg::EV_OPENED, 32'd200, 1'b1,
                                         lss_pkg::PH_OPENING, 1, 1, 0, 0, 22'd0, 16'd0));
        directed_rows.push_back(dir_want(lss_pkg::ACT_EVENT, lss_pkg::EV_OPENED, 32'd210, 1'b0,
                                         lss_pkg::PH_OPENING, 0, 0, 0, 0, 22'd0, 16'd0));
        directed_rows.push_back(dir(lss_pkg::ACT_EVENT, lss_pkg::EV_ERROR, 32'd220, 1'b0));
        // Opened and failed on one tick: auth pulse, then back-off.
        directed_rows.push_back(dir_want(lss_pkg::ACT_TICK, lss_pkg::EV_OPENED, 32'd300, 1'b0,
                                         lss_pkg::PH_BACKOFF, 0, 1, 1, 0, 22'd2000, 16'd1));
        directed_rows.push_back(dir(lss_pkg::ACT_TICK, lss_pkg::EV_OPENED,
                                    32'h4000_0000, 1'b1));
        directed_rows.push_back(dir(lss_pkg::ACT_EVENT, lss_pkg::EV_OPENED,
                                    32'h4000_0001, 1'b0));
        directed_rows.push_back(dir(lss_pkg::ACT_TICK, lss_pkg::EV_CLOSED,
                                    32'h4000_0002, 1'b0));
        directed_rows.push_back(dir(lss_pkg::ACT_EVENT, lss_pkg::EV_AUTHED,
                                    32'h4000_0003, 1'b0));
        // Authenticated and timed out on one tick.
        directed_rows.push_back(dir(lss_pkg::ACT_TICK, lss_pkg::EV_OPENED,
                                    32'h4000_4E30, 1'b0));
        directed_rows.push_back(dir(lss_pkg::ACT_CONNECT, lss_pkg::EV_OPENED,
                                    32'h5000_0000, 1'b1));
        directed_rows.push_back(dir(lss_pkg::ACT_EVENT, lss_pkg::EV_OPENED,
                                    32'h5000_0001, 1'b0));
        directed_rows.push_back(dir(lss_pkg::ACT_TICK, lss_pkg::EV_OPENED,
                                    32'h5000_0002, 1'b0));
        directed_rows.push_back(dir(lss_pkg::ACT_EVENT, lss_pkg::EV_AUTHED,
                                    32'h5000_0003, 1'b0));
        directed_rows.push_back(dir(lss_pkg::ACT_TICK, lss_pkg::EV_OPENED,
                                    32'h5000_0007, 1'b0));
        directed_rows.push_back(dir(lss_pkg::ACT_TICK, lss_pkg::EV_OPENED,
                                    32'h5000_7537, 1'b0));
        directed_rows.push_back(dir(lss_pkg::ACT_EVENT, lss_pkg::EV_CLOSED,
                                    32'h5000_7538, 1'b0));
        directed_rows.push_back(dir(lss_pkg::ACT_TICK, lss_pkg::EV_OPENED,
                                    32'h5000_7540, 1'b0));
        directed_rows.push_back(dir(lss_pkg::ACT_CONNECT, lss_pkg::EV_OPENED,
                                    32'h5000_7600, 1'b1));
        directed_rows.push_back(dir(lss_pkg::ACT_DISCONNECT, lss_pkg::EV_OPENED,
                                    32'h5000_7700, 1'b0));

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].stim);
            pred = supervise_step(directed_rows[i].stim);
            expected_status_q.push_back(directed_rows[i].typed ? directed_rows[i].want : pred);
        end
        wall_ms = 32'h5000_8000;

        // Random phases, each under its own register setting.
        for (ph = 0; ph < SETTING_COUNT; ph++) begin
            wait_drained();
            if (ph == 6) begin
                for (j = 0; j < 4; j++) reg_plan[ph][j] = 22'($urandom_range(1, 20000));
                cfg_write(REG_SPARE, 22'($urandom));
            end
            cfg_write(4'(lss_pkg::REG_BASE), reg_plan[ph][0]);
            cfg_write(4'(lss_pkg::REG_MAX),  reg_plan[ph][1]);
            cfg_write(4'(lss_pkg::REG_AUTH), reg_plan[ph][2]);
            cfg_write(4'(lss_pkg::REG_BEAT), reg_plan[ph][3]);
            if (ph == 1) wall_ms = 32'hFFFF_FF00;
            if (ph == 5) wall_ms = 32'h7FFF_FF00;
            calm = (ph == SETTING_COUNT - 1);
            for (n = 0; n < ITEMS_PER_SET; n++) begin
                if (ph == 3 && n == 40) hold_req = 1'b1;
                if (ph == 4 && n == 50) wait_drained();
                if (!calm && $urandom_range(0, 9) == 0) begin
                    gap = $urandom_range(1, 17);
                    @(negedge aclk);
                    s_valid <= 1'b0;
                    repeat (gap - 1) @(negedge aclk);
                end
                it = pick_item();
                send_item(it);
                expected_status_q.push_back(supervise_step(it));
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_status_q.size() != 0) fault_count++;
        if (fault_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/lss_pkg.sv
sv/lss_backoff_dbl.sv
sv/lss_jitter_div.sv
sv/link_session_supervisor_top.sv
sv/lss_checker.sv
test/link_session_supervisor_top_tb.sv
